[hw/rtl/sgi_pkg.sv]
package sgi_pkg;

    // Coordinate width; every internal width follows from it.
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;   // endpoint differences
    localparam int PROD_W  = 2 * DIFF_W;    // one cross-product term
    localparam int SUM_W   = PROD_W + 1;    // difference of two terms
    localparam int MAG_W   = PROD_W;        // magnitude of the denominator
    localparam int QUO_W   = COORD_W;       // quotient bits, one per divide step
    localparam int NUM_W   = MAG_W + QUO_W; // scaled numerator

    typedef logic signed [COORD_W-1:0] coord_t;

    // Item as it travels through the divide pipeline.
    typedef struct packed {
        coord_t             p0x;
        coord_t             p0y;
        logic               hit;
        logic               neg_x;
        logic               neg_y;
        logic [MAG_W-1:0]   den;
        logic [MAG_W-1:0]   rem_x;
        logic [MAG_W-1:0]   rem_y;
        logic [QUO_W-1:0]   low_x;
        logic [QUO_W-1:0]   low_y;
        logic [QUO_W-1:0]   q_x;
        logic [QUO_W-1:0]   q_y;
    } div_t;

endpackage

[hw/rtl/sgi_front.sv]
module sgi_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sgi_pkg::coord_t       a_start_x,
    input  sgi_pkg::coord_t       a_start_y,
    input  sgi_pkg::coord_t       a_end_x,
    input  sgi_pkg::coord_t       a_end_y,
    input  sgi_pkg::coord_t       b_start_x,
    input  sgi_pkg::coord_t       b_start_y,
    input  sgi_pkg::coord_t       b_end_x,
    input  sgi_pkg::coord_t       b_end_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sgi_pkg::div_t         out_data
);

    typedef logic signed [sgi_pkg::DIFF_W-1:0] diff_w_t;
    typedef logic signed [sgi_pkg::PROD_W-1:0] prod_w_t;
    typedef logic signed [sgi_pkg::SUM_W-1:0]  sum_w_t;

    typedef struct packed {
        sgi_pkg::coord_t p0x;
        sgi_pkg::coord_t p0y;
        diff_w_t         s1x;
        diff_w_t         s1y;
        diff_w_t         s2x;
        diff_w_t         s2y;
        diff_w_t         dx;
        diff_w_t         dy;
    } diff_t;

    typedef struct packed {
        sgi_pkg::coord_t p0x;
        sgi_pkg::coord_t p0y;
        diff_w_t         s1x;
        diff_w_t         s1y;
        prod_w_t         pa;
        prod_w_t         pb;
        prod_w_t         pc;
        prod_w_t         pd;
        prod_w_t         pe;
        prod_w_t         pf;
    } prod_t;

    typedef struct packed {
        sgi_pkg::coord_t p0x;
        sgi_pkg::coord_t p0y;
        diff_w_t         s1x;
        diff_w_t         s1y;
        sum_w_t          den;
        sum_w_t          sn;
        sum_w_t          tn;
    } sum_t;

    typedef struct packed {
        sgi_pkg::coord_t               p0x;
        sgi_pkg::coord_t               p0y;
        logic                          hit;
        logic                          neg_x;
        logic                          neg_y;
        logic [sgi_pkg::QUO_W-1:0]     mag_x;
        logic [sgi_pkg::QUO_W-1:0]     mag_y;
        logic [sgi_pkg::MAG_W-1:0]     tnum;
        logic [sgi_pkg::MAG_W-1:0]     den;
    } test_t;

    diff_t         s1_reg, s1_next;
    prod_t         s2_reg, s2_next;
    sum_t          s3_reg, s3_next;
    test_t         s4_reg, s4_next;
    sgi_pkg::div_t s5_reg, s5_next;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // A stage takes a new item when empty or when its item moves on.
    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: direction vectors and start offset.
    always_comb
    begin
        s1_next.p0x = a_start_x;
        s1_next.p0y = a_start_y;
        s1_next.s1x = diff_w_t'(a_end_x) - diff_w_t'(a_start_x);
        s1_next.s1y = diff_w_t'(a_end_y) - diff_w_t'(a_start_y);
        s1_next.s2x = diff_w_t'(b_end_x) - diff_w_t'(b_start_x);
        s1_next.s2y = diff_w_t'(b_end_y) - diff_w_t'(b_start_y);
        s1_next.dx  = diff_w_t'(a_start_x) - diff_w_t'(b_start_x);
        s1_next.dy  = diff_w_t'(a_start_y) - diff_w_t'(b_start_y);
    end

    // Stage 2: the six cross-product terms.
    always_comb
    begin
        s2_next.p0x = s1_reg.p0x;
        s2_next.p0y = s1_reg.p0y;
        s2_next.s1x = s1_reg.s1x;
        s2_next.s1y = s1_reg.s1y;
        s2_next.pa  = prod_w_t'(s1_reg.s1x) * prod_w_t'(s1_reg.s2y);
        s2_next.pb  = prod_w_t'(s1_reg.s2x) * prod_w_t'(s1_reg.s1y);
        s2_next.pc  = prod_w_t'(s1_reg.s1x) * prod_w_t'(s1_reg.dy);
        s2_next.pd  = prod_w_t'(s1_reg.s1y) * prod_w_t'(s1_reg.dx);
        s2_next.pe  = prod_w_t'(s1_reg.s2x) * prod_w_t'(s1_reg.dy);
        s2_next.pf  = prod_w_t'(s1_reg.s2y) * prod_w_t'(s1_reg.dx);
    end

    // Stage 3: denominator and the two numerators.
    always_comb
    begin
        s3_next.p0x = s2_reg.p0x;
        s3_next.p0y = s2_reg.p0y;
        s3_next.s1x = s2_reg.s1x;
        s3_next.s1y = s2_reg.s1y;
        s3_next.den = sum_w_t'(s2_reg.pa) - sum_w_t'(s2_reg.pb);
        s3_next.sn  = sum_w_t'(s2_reg.pc) - sum_w_t'(s2_reg.pd);
        s3_next.tn  = sum_w_t'(s2_reg.pe) - sum_w_t'(s2_reg.pf);
    end

    // Stage 4: range tests against the signed denominator, sign-normalize t.
    logic    den_neg, den_zero, s_ok, t_ok;
    sum_w_t  den_abs, tn_norm;
    diff_w_t abs_x, abs_y;

    always_comb
    begin
        den_neg  = s3_reg.den[sgi_pkg::SUM_W-1];
        den_zero = (s3_reg.den == '0);
        if (den_neg)
        begin
            s_ok = (s3_reg.sn <= 0) && (s3_reg.sn >= s3_reg.den);
            t_ok = (s3_reg.tn <= 0) && (s3_reg.tn >= s3_reg.den);
        end
        else
        begin
            s_ok = (s3_reg.sn >= 0) && (s3_reg.sn <= s3_reg.den);
            t_ok = (s3_reg.tn >= 0) && (s3_reg.tn <= s3_reg.den);
        end
        den_abs = den_neg ? -s3_reg.den : s3_reg.den;
        tn_norm = den_neg ? -s3_reg.tn : s3_reg.tn;
        abs_x   = s3_reg.s1x[sgi_pkg::DIFF_W-1] ? -s3_reg.s1x : s3_reg.s1x;
        abs_y   = s3_reg.s1y[sgi_pkg::DIFF_W-1] ? -s3_reg.s1y : s3_reg.s1y;

        s4_next.p0x   = s3_reg.p0x;
        s4_next.p0y   = s3_reg.p0y;
        s4_next.hit   = !den_zero && s_ok && t_ok;
        s4_next.neg_x = s3_reg.s1x[sgi_pkg::DIFF_W-1];
        s4_next.neg_y = s3_reg.s1y[sgi_pkg::DIFF_W-1];
        s4_next.mag_x = abs_x[sgi_pkg::QUO_W-1:0];
        s4_next.mag_y = abs_y[sgi_pkg::QUO_W-1:0];
        s4_next.tnum  = tn_norm[sgi_pkg::MAG_W-1:0];
        s4_next.den   = den_abs[sgi_pkg::MAG_W-1:0];
    end

    // Stage 5: scale t by each direction magnitude, split into divider start.
    logic [sgi_pkg::NUM_W-1:0] num_x, num_y;

    always_comb
    begin
        num_x = sgi_pkg::NUM_W'(s4_reg.tnum) * sgi_pkg::NUM_W'(s4_reg.mag_x);
        num_y = sgi_pkg::NUM_W'(s4_reg.tnum) * sgi_pkg::NUM_W'(s4_reg.mag_y);

        s5_next.p0x   = s4_reg.p0x;
        s5_next.p0y   = s4_reg.p0y;
        s5_next.hit   = s4_reg.hit;
        s5_next.neg_x = s4_reg.neg_x;
        s5_next.neg_y = s4_reg.neg_y;
        s5_next.den   = s4_reg.den;
        s5_next.rem_x = num_x[sgi_pkg::NUM_W-1:sgi_pkg::QUO_W];
        s5_next.rem_y = num_y[sgi_pkg::NUM_W-1:sgi_pkg::QUO_W];
        s5_next.low_x = num_x[sgi_pkg::QUO_W-1:0];
        s5_next.low_y = num_y[sgi_pkg::QUO_W-1:0];
        s5_next.q_x   = '0;
        s5_next.q_y   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid) s1_reg <= s1_next;
        if (rdy2 && v1_reg)   s2_reg <= s2_next;
        if (rdy3 && v2_reg)   s3_reg <= s3_next;
        if (rdy4 && v3_reg)   s4_reg <= s4_next;
        if (rdy5 && v4_reg)   s5_reg <= s5_next;
    end

    assign out_valid = v5_reg;
    assign out_data  = s5_reg;

    a_hit_needs_den: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && s4_reg.hit |-> s4_reg.den != '0 && s4_reg.tnum <= s4_reg.den)
        else $error("hit flagged with zero denominator or t above one");

endmodule

[hw/rtl/sgi_div_step.sv]
module sgi_div_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sgi_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output sgi_pkg::div_t out_data
);

    sgi_pkg::div_t data_reg, data_next;
    logic          valid_reg;

    logic [sgi_pkg::MAG_W:0] trial_x, trial_y, sub_x, sub_y;
    logic                    take_x, take_y;

    // One restoring step per lane: shift in the next numerator bit, subtract if it fits.
    always_comb
    begin
        trial_x = {in_data.rem_x, in_data.low_x[sgi_pkg::QUO_W-1]};
        trial_y = {in_data.rem_y, in_data.low_y[sgi_pkg::QUO_W-1]};
        sub_x   = trial_x - {1'b0, in_data.den};
        sub_y   = trial_y - {1'b0, in_data.den};
        take_x  = !sub_x[sgi_pkg::MAG_W];
        take_y  = !sub_y[sgi_pkg::MAG_W];

        data_next       = in_data;
        data_next.rem_x = take_x ? sub_x[sgi_pkg::MAG_W-1:0] : trial_x[sgi_pkg::MAG_W-1:0];
        data_next.rem_y = take_y ? sub_y[sgi_pkg::MAG_W-1:0] : trial_y[sgi_pkg::MAG_W-1:0];
        data_next.low_x = {in_data.low_x[sgi_pkg::QUO_W-2:0], 1'b0};
        data_next.low_y = {in_data.low_y[sgi_pkg::QUO_W-2:0], 1'b0};
        data_next.q_x   = {in_data.q_x[sgi_pkg::QUO_W-2:0], take_x};
        data_next.q_y   = {in_data.q_y[sgi_pkg::QUO_W-2:0], take_y};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.hit |-> data_reg.rem_x < data_reg.den
                                   && data_reg.rem_y < data_reg.den)
        else $error("divider remainder not below denominator on a hit");

endmodule

[hw/rtl/sgi_out_stage.sv]
module sgi_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sgi_pkg::div_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            hit,
    output sgi_pkg::coord_t cross_x,
    output sgi_pkg::coord_t cross_y
);

    typedef logic signed [sgi_pkg::COORD_W:0] ext_t;

    logic            valid_reg;
    logic            hit_reg, hit_next;
    sgi_pkg::coord_t x_reg, x_next, y_reg, y_next;
    ext_t            qx, qy, sum_x, sum_y;

    // Apply the direction sign to each quotient and add it to the start point.
    always_comb
    begin
        qx       = ext_t'({1'b0, in_data.q_x});
        qy       = ext_t'({1'b0, in_data.q_y});
        sum_x    = ext_t'(in_data.p0x) + (in_data.neg_x ? -qx : qx);
        sum_y    = ext_t'(in_data.p0y) + (in_data.neg_y ? -qy : qy);
        hit_next = in_data.hit;
        x_next   = in_data.hit ? sum_x[sgi_pkg::COORD_W-1:0] : '0;
        y_next   = in_data.hit ? sum_y[sgi_pkg::COORD_W-1:0] : '0;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hit_reg <= hit_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
        end
    end

    assign out_valid = valid_reg;
    assign hit       = hit_reg;
    assign cross_x   = x_reg;
    assign cross_y   = y_reg;

endmodule

[hw/rtl/segment_intersection_top.sv]
// Two-segment intersection in signed Q11.4 fixed point. Each input item holds
// the start and end points of segments a and b; each produces exactly one
// result item: hit, and the crossing point a_start + t*(a_end - a_start) with
// the quotient rounded toward zero, or zero coordinates when there is no hit.
// Parallel, collinear and degenerate segments (zero cross-product
// denominator) always report no hit. The block is a fully pipelined datapath:
// it takes one item per clock cycle when the output side keeps up. Each item
// passes in order through 5 front stages (differences, products, cross sums,
// range tests, numerator scaling), one restoring divide step per quotient bit
// (16 stages, x and y divided side by side), and the output register. Every
// stage holds its own valid bit, so a stall on the output fills empty stages
// first and input stays ready while any bubble remains.
module segment_intersection_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sgi_pkg::coord_t a_start_x,
    input  sgi_pkg::coord_t a_start_y,
    input  sgi_pkg::coord_t a_end_x,
    input  sgi_pkg::coord_t a_end_y,
    input  sgi_pkg::coord_t b_start_x,
    input  sgi_pkg::coord_t b_start_y,
    input  sgi_pkg::coord_t b_end_x,
    input  sgi_pkg::coord_t b_end_y,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            hit,
    output sgi_pkg::coord_t cross_x,
    output sgi_pkg::coord_t cross_y
);

    localparam int STEPS = sgi_pkg::QUO_W;

    // Divider chain links: entry 0 comes from the front end, entry STEPS
    // feeds the output register.
    sgi_pkg::div_t div_data  [STEPS+1];
    logic          div_valid [STEPS+1];
    logic          div_ready [STEPS+1];

    sgi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_start_x (a_start_x),
        .a_start_y (a_start_y),
        .a_end_x   (a_end_x),
        .a_end_y   (a_end_y),
        .b_start_x (b_start_x),
        .b_start_y (b_start_y),
        .b_end_x   (b_end_x),
        .b_end_y   (b_end_y),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    // One quotient bit per stage, most significant first.
    for (genvar i = 0; i < STEPS; i++)
    begin : g_div
        sgi_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[i]),
            .in_ready  (div_ready[i]),
            .in_data   (div_data[i]),
            .out_valid (div_valid[i+1]),
            .out_ready (div_ready[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    // Sign, offset and zero-on-miss; this register holds the result item.
    sgi_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[STEPS]),
        .in_ready  (div_ready[STEPS]),
        .in_data   (div_data[STEPS]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .cross_x   (cross_x),
        .cross_y   (cross_y)
    );

    // A miss must never leak a stale point.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> cross_x == '0 && cross_y == '0)
        else $error("result without hit carries a nonzero point");

    // With the output register empty, every stage can move, so input is open.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output register is empty");

    // Nothing may come out of an empty pipeline right after reset.
    a_no_early_out: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result item appeared directly after reset");

endmodule
